/* design/bmhq_pkg.sv */
// Shared types and constants of the binary max-heap queue.
// No dependencies; every other design file imports this package.

package bmhq_pkg;

  // Fixed field widths of the request and response items
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 6;
  localparam int TOTAL_W = 7;

  // Default heap depth
  localparam int CAPACITY_DEF = 64;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_CHANGE  = 2'd2,
    REQ_DELETE  = 2'd3
  } req_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_CHG,
    S_DEL_TAKE,
    S_DEL_PATH,
    S_LAST_RD,
    S_LAST,
    S_DOWN,
    S_FIN_WR,
    S_DONE
  } state_e;

endpackage

/* design/bmhq_req_if.sv */
// Request channel of the heap queue: valid/ready handshake and request payload.
// Depends on bmhq_pkg.

interface bmhq_req_if import bmhq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  req_e                    req_type;
  logic signed [VAL_W-1:0] value;
  logic [IDX_W-1:0]        index;

  modport source (output valid, req_type, value, index, input ready);
  modport sink   (input valid, req_type, value, index, output ready);
endinterface

/* design/bmhq_rsp_if.sv */
// Response channel of the heap queue: valid/ready handshake and result payload.
// Depends on bmhq_pkg.

interface bmhq_rsp_if import bmhq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_e                 status;
  logic signed [VAL_W-1:0] taken_value;
  logic [TOTAL_W-1:0]      entry_total;
  logic signed [VAL_W-1:0] top_value;
  logic                    top_valid;

  modport source (output valid, status, taken_value, entry_total, top_value, top_valid,
                  input ready);
  modport sink   (input valid, status, taken_value, entry_total, top_value, top_valid,
                  output ready);
endinterface

/* design/binary_max_heap_queue.sv */
// Binary max-heap priority queue of signed 32-bit priorities.
// Depends on bmhq_pkg, bmhq_req_if and bmhq_rsp_if.
//
// Usage:
//   req_i carries one request item: insert, extract maximum, change priority
//   at an index, or delete at an index. rsp_o returns exactly one item per
//   request with status, value taken out, entry count and current maximum.
//   Requests are served one at a time. A sift moves one tree level per cycle,
//   paced by the registered reads of the heap memory (two read ports, one
//   write port).
//   The finished response sits in an output register, so the next request is
//   accepted while it waits; a stalled receiver blocks only the completion of
//   the following request.
//   Reset empties the heap at once (count cleared); the heap memory itself is
//   not cleared and entries beyond the count are never used.

module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // Control and datapath registers
  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic signed [VAL_W-1:0] cur_q, cur_d;
  logic signed [VAL_W-1:0] taken_q, taken_d;
  status_e                 stat_q, stat_d;
  logic signed [VAL_W-1:0] root_q;

  // Response register
  logic                    out_valid_q, out_valid_d;
  status_e                 out_stat_q, out_stat_d;
  logic signed [VAL_W-1:0] out_taken_q, out_taken_d;
  logic [TOTAL_W-1:0]      out_total_q, out_total_d;
  logic signed [VAL_W-1:0] out_top_q, out_top_d;
  logic                    out_topv_q, out_topv_d;

  // Heap memory ports
  logic signed [VAL_W-1:0] heap_mem [CAPACITY];
  logic [AW-1:0]           rd_a_addr, rd_b_addr;
  logic signed [VAL_W-1:0] rd_a_q, rd_b_q;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  // Handshake and decode
  logic in_fire, out_free, is_empty, is_full, idx_bad;
  assign in_fire  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == CAP_CNT);
  assign idx_bad  = XW'(req_i.index) >= XW'(cnt_q);

  // Tree navigation around the current position
  logic [AW-1:0] par_idx, gpar_idx;
  logic [XW-1:0] l_cur, r_cur;
  assign par_idx  = (idx_q - AW'(1)) >> 1;
  assign gpar_idx = (par_idx - AW'(1)) >> 1;
  assign l_cur    = (XW'(idx_q) << 1) + XW'(1);
  assign r_cur    = l_cur + XW'(1);

  // Sift-up compare: parent smaller than the moving value
  logic up_move;
  assign up_move = rd_a_q < cur_q;

  // Sift-down compare: pick the larger live child above the moving value
  logic                    l_ok, r_ok, take_l, take_r, down_move;
  logic signed [VAL_W-1:0] best_l_val, move_val;
  logic [XW-1:0]           best_x, nl_x, nr_x;
  assign l_ok       = l_cur < XW'(cnt_q);
  assign r_ok       = r_cur < XW'(cnt_q);
  assign take_l     = l_ok && (rd_a_q > cur_q);
  assign best_l_val = take_l ? rd_a_q : cur_q;
  assign take_r     = r_ok && (rd_b_q > best_l_val);
  assign down_move  = take_l || take_r;
  assign move_val   = take_r ? rd_b_q : rd_a_q;
  assign best_x     = take_r ? r_cur : l_cur;
  assign nl_x       = (best_x << 1) + XW'(1);
  assign nr_x       = nl_x + XW'(1);

  // Change priority: new value above the old one sifts up
  logic chg_up;
  assign chg_up = cur_q > rd_a_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (req_i.req_type)
            REQ_INSERT: begin
              if (is_full) state_d = S_DONE;
              else if (is_empty) state_d = S_FIN_WR;
              else state_d = S_UP;
            end
            REQ_EXTRACT: state_d = is_empty ? S_DONE : S_LAST;
            REQ_CHANGE:  state_d = (is_empty || idx_bad) ? S_DONE : S_CHG;
            REQ_DELETE:  state_d = (is_empty || idx_bad) ? S_DONE : S_DEL_TAKE;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_UP: begin
        if (!up_move) state_d = S_DONE;
        else if (par_idx == '0) state_d = S_FIN_WR;
      end
      S_CHG: begin
        if (!chg_up) state_d = S_DOWN;
        else if (idx_q == '0) state_d = S_FIN_WR;
        else state_d = S_UP;
      end
      S_DEL_TAKE: state_d = (idx_q == '0) ? S_LAST_RD : S_DEL_PATH;
      S_DEL_PATH: begin
        if (par_idx == '0) state_d = S_LAST_RD;
      end
      S_LAST_RD: state_d = S_LAST;
      S_LAST:    state_d = is_empty ? S_DONE : S_DOWN;
      S_DOWN: begin
        if (!down_move) state_d = S_DONE;
      end
      S_FIN_WR: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory control and response load
  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    taken_d     = taken_q;
    stat_d      = stat_q;
    rd_a_addr   = idx_q;
    rd_b_addr   = idx_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = cur_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_stat_d  = out_stat_q;
    out_taken_d = out_taken_q;
    out_total_d = out_total_q;
    out_top_d   = out_top_q;
    out_topv_d  = out_topv_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          stat_d  = ST_OK;
          taken_d = '0;
          cur_d   = req_i.value;
          case (req_i.req_type)
            REQ_INSERT: begin
              if (is_full) begin
                stat_d = ST_FULL;
              end else begin
                idx_d     = AW'(cnt_q);
                cnt_d     = cnt_q + CW'(1);
                rd_a_addr = AW'((cnt_q - CW'(1)) >> 1);
              end
            end
            REQ_EXTRACT: begin
              if (is_empty) begin
                stat_d = ST_EMPTY;
              end else begin
                taken_d   = root_q;
                rd_a_addr = AW'(cnt_q - CW'(1));
                cnt_d     = cnt_q - CW'(1);
              end
            end
            default: begin
              if (is_empty) begin
                stat_d = ST_EMPTY;
              end else if (idx_bad) begin
                stat_d = ST_BAD_IDX;
              end else begin
                idx_d     = AW'(req_i.index);
                rd_a_addr = AW'(req_i.index);
              end
            end
          endcase
        end
      end
      // Pull the smaller parent down, or settle the value here
      S_UP: begin
        wr_en = 1'b1;
        if (up_move) begin
          wr_data   = rd_a_q;
          idx_d     = par_idx;
          rd_a_addr = gpar_idx;
        end
      end
      S_CHG: begin
        if (chg_up) begin
          rd_a_addr = par_idx;
        end else begin
          rd_a_addr = AW'(l_cur);
          rd_b_addr = AW'(r_cur);
        end
      end
      // Capture the deleted value and start shifting the path down
      S_DEL_TAKE: begin
        taken_d   = rd_a_q;
        rd_a_addr = par_idx;
      end
      S_DEL_PATH: begin
        wr_en     = 1'b1;
        wr_data   = rd_a_q;
        idx_d     = par_idx;
        rd_a_addr = gpar_idx;
      end
      // Fetch the last entry once the path writes have landed
      S_LAST_RD: begin
        rd_a_addr = AW'(cnt_q - CW'(1));
        cnt_d     = cnt_q - CW'(1);
      end
      S_LAST: begin
        cur_d     = rd_a_q;
        idx_d     = '0;
        rd_a_addr = AW'(XW'(1));
        rd_b_addr = AW'(XW'(2));
      end
      // Lift the larger child, or settle the value here
      S_DOWN: begin
        wr_en = 1'b1;
        if (down_move) begin
          wr_data   = move_val;
          idx_d     = AW'(best_x);
          rd_a_addr = AW'(nl_x);
          rd_b_addr = AW'(nr_x);
        end
      end
      S_FIN_WR: wr_en = 1'b1;
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_taken_d = taken_q;
          out_total_d = TOTAL_W'(cnt_q);
          out_topv_d  = !is_empty;
          out_top_d   = is_empty ? '0 : root_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cur_q       <= cur_d;
    taken_q     <= taken_d;
    stat_q      <= stat_d;
    out_stat_q  <= out_stat_d;
    out_taken_q <= out_taken_d;
    out_total_q <= out_total_d;
    out_top_q   <= out_top_d;
    out_topv_q  <= out_topv_d;
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) heap_mem[wr_addr] <= wr_data;
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // Shadow copy of the root entry
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr == '0)) root_q <= wr_data;
  end

  // Channel outputs
  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_stat_q;
  assign rsp_o.taken_value = out_taken_q;
  assign rsp_o.entry_total = out_total_q;
  assign rsp_o.top_value   = out_top_q;
  assign rsp_o.top_valid   = out_topv_q;

endmodule

/* design/bmhq_checker.sv */
// Port-level checks of the heap queue responses, bound to the top level.
// Depends on bmhq_pkg and binary_max_heap_queue.

module bmhq_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input status_e                 status_i,
  input logic signed [VAL_W-1:0] taken_value_i,
  input logic [TOTAL_W-1:0]      entry_total_i,
  input logic signed [VAL_W-1:0] top_value_i,
  input logic                    top_valid_i
);

  // Hold a stalled response item (status, entry count and maximum)
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(entry_total_i)
      && $stable(status_i) && $stable(top_value_i))
    else $error("stalled response item changed");

  // Top flag follows the entry count
  a_top_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> top_valid_i == (entry_total_i != '0))
    else $error("top_valid disagrees with entry_total");

  // Empty heap reports a zero maximum
  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !top_valid_i |-> top_value_i == '0)
    else $error("empty heap reports nonzero top_value");

  // Rejected requests take nothing out
  a_taken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> taken_value_i == '0)
    else $error("rejected request reports a taken value");

  // Count never exceeds the depth
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(entry_total_i) <= CAPACITY)
    else $error("entry_total beyond capacity");

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .taken_value_i (rsp_o.taken_value),
  .entry_total_i (rsp_o.entry_total),
  .top_value_i   (rsp_o.top_value),
  .top_valid_i   (rsp_o.top_valid)
);

/* tb/testbench.sv */
// Self-checking testbench for binary_max_heap_queue: drives request items and
// checks every response item against a heap predictor kept in the testbench.
// Depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and the binary_max_heap_queue RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int HEAP_DEPTH  = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] taken;
    logic [TOTAL_W-1:0]      total;
    logic signed [VAL_W-1:0] top;
    logic                    top_ok;
  } heap_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmhq_req_if req_if ();
  bmhq_rsp_if rsp_if ();

  binary_max_heap_queue #(.CAPACITY(HEAP_DEPTH)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Predicted heap contents and the responses still owed by the block
  logic signed [VAL_W-1:0] heap_mem [HEAP_DEPTH];
  int                      heap_cnt = 0;
  heap_rsp_t               pending_rsp [$];

  int  errors    = 0;
  int  n_req [4] = '{default: 0};
  int  n_stat [4] = '{default: 0};
  int  n_rsp     = 0;
  int  peak_cnt  = 0;
  bit  quiet     = 1'b0;
  int  hold_reqs = 0;

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------

  function automatic void heap_swap(int a, int b);
    logic signed [VAL_W-1:0] t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void heap_rise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(heap_mem[p] < heap_mem[i])) break;
      heap_swap(p, i);
      i = p;
    end
  endfunction

  function automatic void heap_sink(int i);
    int best;
    int l;
    while (i < heap_cnt) begin
      best = i;
      l    = 2 * i + 1;
      if (l < heap_cnt && heap_mem[l] > heap_mem[best]) best = l;
      if (l + 1 < heap_cnt && heap_mem[l + 1] > heap_mem[best]) best = l + 1;
      if (best == i) break;
      heap_swap(i, best);
      i = best;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] heap_pop_root();
    logic signed [VAL_W-1:0] got;
    got         = heap_mem[0];
    heap_cnt    = heap_cnt - 1;
    heap_mem[0] = heap_mem[heap_cnt];
    heap_sink(0);
    return got;
  endfunction

  // Apply one request to the predicted heap and return the response it owes
  function automatic heap_rsp_t heap_serve(req_e kind, logic signed [VAL_W-1:0] val,
                                           logic [IDX_W-1:0] idx);
    heap_rsp_t               r;
    logic signed [VAL_W-1:0] old;
    int                      i;
    r        = '0;
    r.status = ST_OK;
    i        = int'(idx);
    if (kind == REQ_INSERT) begin
      if (heap_cnt >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        heap_mem[heap_cnt] = val;
        heap_cnt           = heap_cnt + 1;
        heap_rise(heap_cnt - 1);
      end
    end else if (heap_cnt == 0) begin
      r.status = ST_EMPTY;
    end else if (kind == REQ_EXTRACT) begin
      r.taken = heap_pop_root();
    end else if (i >= heap_cnt) begin
      r.status = ST_BAD_IDX;
    end else if (kind == REQ_CHANGE) begin
      old         = heap_mem[i];
      heap_mem[i] = val;
      if (val > old) heap_rise(i);
      else heap_sink(i);
    end else begin
      // walk the entry to the root along its path, then take it
      while (i > 0) begin
        heap_swap((i - 1) / 2, i);
        i = (i - 1) / 2;
      end
      r.taken = heap_pop_root();
    end
    r.total  = TOTAL_W'(heap_cnt);
    r.top_ok = (heap_cnt > 0);
    r.top    = (heap_cnt > 0) ? heap_mem[0] : '0;
    if (heap_cnt > peak_cnt) peak_cnt = heap_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request item and hold it until the block takes it
  task automatic send_req(req_e kind, logic signed [VAL_W-1:0] val, logic [IDX_W-1:0] idx);
    heap_rsp_t owed;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 17) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= val;
    req_if.index    <= idx;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    owed        = heap_serve(kind, val, idx);
    pending_rsp = {pending_rsp, owed};
    n_req[kind]++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return VAL_W'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Mostly live positions, sometimes anywhere in the index range
  function automatic logic [IDX_W-1:0] pick_index();
    if (heap_cnt > 0 && $urandom_range(9) < 8) return IDX_W'($urandom_range(heap_cnt - 1));
    return IDX_W'($urandom_range(2 ** IDX_W - 1));
  endfunction

  // Random request mix; weights are percentages, delete takes the remainder
  task automatic run_mix(int n, int w_ins, int w_ext, int w_chg);
    int   roll;
    req_e kind;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < w_ins) kind = REQ_INSERT;
      else if (roll < w_ins + w_ext) kind = REQ_EXTRACT;
      else if (roll < w_ins + w_ext + w_chg) kind = REQ_CHANGE;
      else kind = REQ_DELETE;
      send_req(kind, pick_value(), pick_index());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  // Drive ready: random stalls, quiet stretches, and long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(99) >= 17);
      end
    end
  end

  function automatic bit field_bad(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (got === want) return 1'b0;
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
    return 1'b1;
  endfunction

  // Compare each accepted response item with the oldest prediction
  always @(posedge clk_i) begin
    heap_rsp_t want;
    bit        bad;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response item with none expected (status %0d)", $time, rsp_if.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        n_stat[want.status]++;
        bad  = 1'b0;
        bad |= field_bad("status", VAL_W'(want.status), VAL_W'(rsp_if.status));
        bad |= field_bad("taken_value", want.taken, rsp_if.taken_value);
        bad |= field_bad("entry_total", VAL_W'(want.total), VAL_W'(rsp_if.entry_total));
        bad |= field_bad("top_value", want.top, rsp_if.top_value);
        bad |= field_bad("top_valid", VAL_W'(want.top_ok), VAL_W'(rsp_if.top_valid));
        if (bad) errors++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extract, change and delete against an empty heap
  task automatic test_empty_heap();
    send_req(REQ_EXTRACT, 32'sd0, 6'd0);
    send_req(REQ_CHANGE, 32'sd7, 6'd0);
    send_req(REQ_DELETE, 32'sd0, 6'd5);
  endtask

  // Extreme priorities, duplicates, bad indexes, both change directions
  task automatic test_extremes();
    send_req(REQ_INSERT, 32'sh7fff_ffff, 6'd0);
    send_req(REQ_INSERT, 32'sh8000_0000, 6'd0);
    send_req(REQ_INSERT, 32'sd0, 6'd0);
    send_req(REQ_INSERT, -32'sd1, 6'd63);
    send_req(REQ_INSERT, 32'sh7fff_ffff, 6'd0);
    send_req(REQ_CHANGE, 32'sd1, 6'd63);
    send_req(REQ_DELETE, 32'sd0, 6'd5);
    send_req(REQ_CHANGE, 32'sh7fff_fffe, 6'd3);
    send_req(REQ_CHANGE, 32'sh8000_0000, 6'd0);
    send_req(REQ_DELETE, 32'sd0, 6'd4);
    send_req(REQ_DELETE, 32'sd0, 6'd0);
    send_req(REQ_EXTRACT, 32'sd0, 6'd0);
    send_req(REQ_EXTRACT, 32'sd0, 6'd0);
    send_req(REQ_EXTRACT, 32'sd0, 6'd0);
    send_req(REQ_EXTRACT, 32'sd0, 6'd0);
    send_req(REQ_DELETE, 32'sd0, 6'd0);
  endtask

  task automatic test_mixed();
    run_mix(250, 35, 20, 25);
  endtask

  // Insert-heavy: reach capacity, hit the full case, work deep in the tree
  task automatic test_fill();
    run_mix(250, 70, 5, 15);
  endtask

  // Extract-heavy: run the heap dry again
  task automatic test_drain();
    run_mix(150, 10, 50, 20);
  endtask

  // Stretch with no idling on either side
  task automatic test_back_to_back();
    quiet = 1'b1;
    run_mix(150, 35, 25, 20);
    quiet = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_reqs++;
    run_mix(12, 50, 30, 10);
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.value    = '0;
    req_if.index    = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_heap();
    test_extremes();
    test_mixed();
    test_fill();
    test_backpressure();
    test_drain();
    test_back_to_back();
    test_mixed();

    // Drop valid and let the outstanding responses drain
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("summary: %0d requests (insert %0d, extract %0d, change %0d, delete %0d)",
             n_req[0] + n_req[1] + n_req[2] + n_req[3], n_req[0], n_req[1], n_req[2], n_req[3]);
    $display("summary: %0d responses; ok %0d, empty %0d, bad index %0d, full %0d; peak %0d",
             n_rsp, n_stat[0], n_stat[1], n_stat[2], n_stat[3], peak_cnt);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d responses still pending", $time, pending_rsp.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule
